FILE: rtl/sico_pkg.sv
// Shared types, codes and fixed widths for the sphere-in-cylinder overlap checker.
// Used by sico_ctrl, sico_datapath and the top level; depends on nothing else.
`default_nettype none

package sico_pkg;

    // Default values for the top-level parameters.
    localparam int MAX_SPHERES_DEF = 1024;
    localparam int COORD_WIDTH_DEF = 24;

    // Fixed field widths.
    localparam int REG_W       = 23;  // tube_radius, tube_length, diameter
    localparam int CNT_REG_W   = 11;  // particle_count
    localparam int IDX_W       = 10;  // index field of an input item
    localparam int CAUSE_W     = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int OUT_DATA_W  = 8;

    // Magnitudes are clamped to 2^REG_W. Any distance at or above that value is
    // already larger than the diameter and larger than half of (2*radius - diameter),
    // so the clamp never changes a comparison.
    localparam int MAG_W       = REG_W + 1;
    localparam int MAG_MAX     = 1 << REG_W;
    localparam int PROD_W      = 2 * MAG_W;
    localparam int LIM_W       = REG_W + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TUBE_RADIUS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TUBE_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIAMETER       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 2'd3;

    // Item function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Result cause codes.
    localparam logic [CAUSE_W-1:0] CAUSE_NONE   = 2'd0;
    localparam logic [CAUSE_W-1:0] CAUSE_RADIAL = 2'd1;
    localparam logic [CAUSE_W-1:0] CAUSE_CAP    = 2'd2;
    localparam logic [CAUSE_W-1:0] CAUSE_SPHERE = 2'd3;

    // Reset value of the diameter register (1.0 in 8 fraction bits).
    localparam logic [REG_W-1:0] DIAMETER_RESET = 23'd256;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_PREP,
        ST_SQUARE,
        ST_CHECK,
        ST_SCAN,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic store_wr;
        logic prep;
        logic square;
        logic check;
        logic scan_run;
        logic load_out;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic wall_hit;
        logic hit;
        logic scan_done;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/sico_ctrl.sv
// Controller state machine of the overlap checker: sequences one item at a time.
// Depends on sico_pkg for the state type and the command and status structs.
`default_nettype none

module sico_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_valid,
    input  wire logic                 i_s_func,
    output logic                      o_s_ready,
    output logic                      o_m_valid,
    input  wire logic                 i_m_ready,
    input  wire sico_pkg::t_dp_status i_status,
    output sico_pkg::t_dp_cmd         o_cmd
);
    import sico_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    n_state = (i_s_func == FUNC_QUERY) ? ST_PREP : ST_WRITE;
                end
            end
            ST_WRITE:  n_state = ST_DONE;
            ST_PREP:   n_state = ST_SQUARE;
            ST_SQUARE: n_state = ST_CHECK;
            ST_CHECK:  n_state = ST_SCAN;
            ST_SCAN: begin
                if (i_status.wall_hit || i_status.hit || i_status.scan_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_s_ready       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_s_ready       = 1'b1;
                o_cmd.load_item = i_s_valid;
            end
            ST_WRITE:  o_cmd.store_wr = 1'b1;
            ST_PREP:   o_cmd.prep     = 1'b1;
            ST_SQUARE: o_cmd.square   = 1'b1;
            ST_CHECK:  o_cmd.check    = 1'b1;
            ST_SCAN:   o_cmd.scan_run = !i_status.wall_hit && !i_status.hit;
            ST_DONE:   o_cmd.load_out = w_out_free;
            default: begin
                o_s_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_valid = r_out_valid;

`ifndef SYNTHESIS
    a_wall_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && i_status.wall_hit) |=> (r_state == ST_DONE))
        else $error("wall collision did not end the scan");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_s_valid) |=> (r_state != ST_IDLE))
        else $error("accepted item did not start processing");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && w_out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished item was not placed in the output register");
`endif

endmodule

`default_nettype wire

FILE: rtl/sico_datapath.sv
// Datapath of the overlap checker: configuration registers, position store,
// wall tests and the pipelined distance scan. Depends on sico_pkg.
`default_nettype none

module sico_datapath #(
    parameter int MAX_SPHERES = sico_pkg::MAX_SPHERES_DEF,
    parameter int COORD_WIDTH = sico_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire sico_pkg::t_dp_cmd               i_cmd,
    output sico_pkg::t_dp_status                 o_status,
    input  wire logic                            i_cfg_we,
    input  wire logic [sico_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [sico_pkg::REG_W-1:0]      i_cfg_wdata,
    input  wire logic                            i_func,
    input  wire logic [sico_pkg::IDX_W-1:0]      i_index,
    input  wire logic                            i_skip_valid,
    input  wire logic [COORD_WIDTH-1:0]          i_pos_x,
    input  wire logic [COORD_WIDTH-1:0]          i_pos_y,
    input  wire logic [COORD_WIDTH-1:0]          i_pos_z,
    output logic                                 o_collides,
    output logic [sico_pkg::CAUSE_W-1:0]         o_cause
);
    import sico_pkg::*;

    localparam int ADDR_W  = $clog2(MAX_SPHERES);
    localparam int CNT_W   = $clog2(MAX_SPHERES + 1);
    localparam int NCMP_W  = (CNT_W > CNT_REG_W) ? CNT_W : CNT_REG_W;
    localparam int SCMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam int ENT_W   = 3 * COORD_WIDTH;
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PEXT_W  = (COORD_WIDTH > MAG_W) ? COORD_WIDTH : MAG_W;
    localparam int DEXT_W  = (DIFF_W > MAG_W) ? DIFF_W : MAG_W;
    localparam int CAP_W   = ((COORD_WIDTH > REG_W) ? COORD_WIDTH : REG_W) + 2;
    localparam int LIM2_W  = 2 * LIM_W;
    localparam int D2_W    = 2 * REG_W;
    localparam int R2_W    = PROD_W + 1;
    localparam int R2X4_W  = R2_W + 2;
    localparam int DIST_W  = PROD_W + 2;

    // Configuration registers.
    logic [REG_W-1:0]     r_tube_radius;
    logic [REG_W-1:0]     r_tube_length;
    logic [REG_W-1:0]     r_diameter;
    logic [CNT_REG_W-1:0] r_count;

    // Latched item.
    logic                   r_func;
    logic [IDX_W-1:0]       r_idx;
    logic                   r_skip;
    logic [COORD_WIDTH-1:0] r_x;
    logic [COORD_WIDTH-1:0] r_y;
    logic [COORD_WIDTH-1:0] r_z;

    // Wall test registers.
    logic [MAG_W-1:0]       r_mag_px;
    logic [MAG_W-1:0]       r_mag_py;
    logic [COORD_WIDTH-1:0] r_mag_pz;
    logic [LIM_W-1:0]       r_lim;
    logic                   r_lim_ok;
    logic [PROD_W-1:0]      r_sq_px;
    logic [PROD_W-1:0]      r_sq_py;
    logic [LIM2_W-1:0]      r_lim2;
    logic [D2_W-1:0]        r_d2;
    logic                   r_cap_hit;
    logic                   r_lim_ok2;
    logic [CAUSE_W-1:0]     r_wall_cause;

    // Scan pipeline.
    logic [ENT_W-1:0]  r_store [MAX_SPHERES];
    logic [ENT_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    logic [MAG_W-1:0]  r_dm_x;
    logic [MAG_W-1:0]  r_dm_y;
    logic [MAG_W-1:0]  r_dm_z;
    logic [PROD_W-1:0] r_dsq_x;
    logic [PROD_W-1:0] r_dsq_y;
    logic [PROD_W-1:0] r_dsq_z;
    logic              r_hit;

    logic               r_out_collides;
    logic [CAUSE_W-1:0] r_out_cause;

    // Combinational signals.
    logic [NCMP_W-1:0]      w_count_ext;
    logic [NCMP_W-1:0]      w_count_clamp;
    logic [CNT_W-1:0]       w_count_eff;
    logic [SCMP_W-1:0]      w_idx_ext;
    logic                   w_idx_ok;
    logic [ADDR_W-1:0]      w_wr_addr;
    logic [ADDR_W-1:0]      w_rd_addr;
    logic                   w_issue;
    logic                   w_skip_hit;
    logic [COORD_WIDTH-1:0] w_abs_x;
    logic [COORD_WIDTH-1:0] w_abs_y;
    logic [COORD_WIDTH-1:0] w_abs_z;
    logic [PEXT_W-1:0]      w_ext_x;
    logic [PEXT_W-1:0]      w_ext_y;
    logic [LIM_W-1:0]       w_twice_r;
    logic [LIM_W-1:0]       w_diam_ext;
    logic [CAP_W-1:0]       w_cap_lhs;
    logic [R2_W-1:0]        w_r2;
    logic [R2X4_W-1:0]      w_r2x4;
    logic                   w_radial;
    logic [COORD_WIDTH-1:0] w_rd_x;
    logic [COORD_WIDTH-1:0] w_rd_y;
    logic [COORD_WIDTH-1:0] w_rd_z;
    logic [DIFF_W-1:0]      w_dx;
    logic [DIFF_W-1:0]      w_dy;
    logic [DIFF_W-1:0]      w_dz;
    logic [DIFF_W-1:0]      w_adx;
    logic [DIFF_W-1:0]      w_ady;
    logic [DIFF_W-1:0]      w_adz;
    logic [DEXT_W-1:0]      w_edx;
    logic [DEXT_W-1:0]      w_edy;
    logic [DEXT_W-1:0]      w_edz;
    logic [DIST_W-1:0]      w_dist;
    logic [CAUSE_W-1:0]     n_cause;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tube_radius <= '0;
            r_tube_length <= '0;
            r_diameter    <= DIAMETER_RESET;
            r_count       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TUBE_RADIUS:    r_tube_radius <= i_cfg_wdata;
                CFG_TUBE_LENGTH:    r_tube_length <= i_cfg_wdata;
                CFG_DIAMETER:       r_diameter    <= i_cfg_wdata;
                CFG_PARTICLE_COUNT: r_count       <= i_cfg_wdata[CNT_REG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The count of spheres in use is clamped to the store depth.
    assign w_count_ext   = NCMP_W'(r_count);
    assign w_count_clamp = (w_count_ext > NCMP_W'(MAX_SPHERES)) ? NCMP_W'(MAX_SPHERES)
                                                                 : w_count_ext;
    assign w_count_eff   = w_count_clamp[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func <= i_func;
            r_idx  <= i_index;
            r_skip <= i_skip_valid;
            r_x    <= i_pos_x;
            r_y    <= i_pos_y;
            r_z    <= i_pos_z;
        end
    end

    // Position store. Writes beyond the store depth are dropped.
    assign w_idx_ext = SCMP_W'(r_idx);
    assign w_idx_ok  = w_idx_ext < SCMP_W'(MAX_SPHERES);
    assign w_wr_addr = w_idx_ext[ADDR_W-1:0];
    assign w_rd_addr = r_cnt[ADDR_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_wr && w_idx_ok) begin
            r_store[w_wr_addr] <= {r_z, r_y, r_x};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_store[w_rd_addr];
    end

    // Candidate magnitudes and the radial limit 2*radius - diameter.
    assign w_abs_x    = r_x[COORD_WIDTH-1] ? (~r_x + COORD_WIDTH'(1)) : r_x;
    assign w_abs_y    = r_y[COORD_WIDTH-1] ? (~r_y + COORD_WIDTH'(1)) : r_y;
    assign w_abs_z    = r_z[COORD_WIDTH-1] ? (~r_z + COORD_WIDTH'(1)) : r_z;
    assign w_ext_x    = PEXT_W'(w_abs_x);
    assign w_ext_y    = PEXT_W'(w_abs_y);
    assign w_twice_r  = {r_tube_radius, 1'b0};
    assign w_diam_ext = LIM_W'(r_diameter);

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_mag_px <= (w_ext_x >= PEXT_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : w_ext_x[MAG_W-1:0];
            r_mag_py <= (w_ext_y >= PEXT_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : w_ext_y[MAG_W-1:0];
            r_mag_pz <= w_abs_z;
            r_lim_ok <= w_diam_ext <= w_twice_r;
            r_lim    <= w_twice_r - w_diam_ext;
        end
    end

    // End cap test: 2*|z| + diameter > length.
    assign w_cap_lhs = (CAP_W'(r_mag_pz) << 1) + CAP_W'(r_diameter);

    always_ff @(posedge i_clk) begin
        if (i_cmd.square) begin
            r_sq_px   <= PROD_W'(r_mag_px) * PROD_W'(r_mag_px);
            r_sq_py   <= PROD_W'(r_mag_py) * PROD_W'(r_mag_py);
            r_lim2    <= LIM2_W'(r_lim) * LIM2_W'(r_lim);
            r_d2      <= D2_W'(r_diameter) * D2_W'(r_diameter);
            r_cap_hit <= w_cap_lhs > CAP_W'(r_tube_length);
            r_lim_ok2 <= r_lim_ok;
        end
    end

    // Radial test on squares: 4*(x^2 + y^2) > lim^2, or diameter > 2*radius.
    assign w_r2     = R2_W'(r_sq_px) + R2_W'(r_sq_py);
    assign w_r2x4   = {w_r2, 2'b00};
    assign w_radial = !r_lim_ok2 || (w_r2x4 > R2X4_W'(r_lim2));

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            if (w_radial) begin
                r_wall_cause <= CAUSE_RADIAL;
            end else if (r_cap_hit) begin
                r_wall_cause <= CAUSE_CAP;
            end else begin
                r_wall_cause <= CAUSE_NONE;
            end
        end
    end

    // Scan issue: one store entry per cycle, skipping the excluded slot.
    assign w_issue    = i_cmd.scan_run && (r_cnt != w_count_eff);
    assign w_skip_hit = r_skip && (SCMP_W'(r_cnt) == w_idx_ext);

    // Stage one: coordinate differences, magnitudes, clamp.
    assign w_rd_x = r_rd[COORD_WIDTH-1:0];
    assign w_rd_y = r_rd[2*COORD_WIDTH-1:COORD_WIDTH];
    assign w_rd_z = r_rd[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign w_dx   = {w_rd_x[COORD_WIDTH-1], w_rd_x} - {r_x[COORD_WIDTH-1], r_x};
    assign w_dy   = {w_rd_y[COORD_WIDTH-1], w_rd_y} - {r_y[COORD_WIDTH-1], r_y};
    assign w_dz   = {w_rd_z[COORD_WIDTH-1], w_rd_z} - {r_z[COORD_WIDTH-1], r_z};
    assign w_adx  = w_dx[DIFF_W-1] ? (~w_dx + DIFF_W'(1)) : w_dx;
    assign w_ady  = w_dy[DIFF_W-1] ? (~w_dy + DIFF_W'(1)) : w_dy;
    assign w_adz  = w_dz[DIFF_W-1] ? (~w_dz + DIFF_W'(1)) : w_dz;
    assign w_edx  = DEXT_W'(w_adx);
    assign w_edy  = DEXT_W'(w_ady);
    assign w_edz  = DEXT_W'(w_adz);

    // Stage three: squared distance.
    assign w_dist = DIST_W'(r_dsq_x) + DIST_W'(r_dsq_y) + DIST_W'(r_dsq_z);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_hit <= 1'b0;
        end else if (i_cmd.check) begin
            r_cnt <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
            r_v3  <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            if (w_issue) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end
            r_v1 <= w_issue && !w_skip_hit;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (r_v3 && (w_dist < DIST_W'(r_d2))) begin
                r_hit <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dm_x  <= (w_edx >= DEXT_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : w_edx[MAG_W-1:0];
        r_dm_y  <= (w_edy >= DEXT_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : w_edy[MAG_W-1:0];
        r_dm_z  <= (w_edz >= DEXT_W'(MAG_MAX)) ? MAG_W'(MAG_MAX) : w_edz[MAG_W-1:0];
        r_dsq_x <= PROD_W'(r_dm_x) * PROD_W'(r_dm_x);
        r_dsq_y <= PROD_W'(r_dm_y) * PROD_W'(r_dm_y);
        r_dsq_z <= PROD_W'(r_dm_z) * PROD_W'(r_dm_z);
    end

    assign o_status.wall_hit  = r_wall_cause != CAUSE_NONE;
    assign o_status.hit       = r_hit;
    assign o_status.scan_done = (r_cnt == w_count_eff) && !r_v1 && !r_v2 && !r_v3;

    // Result: writes acknowledge with no cause; wall tests take precedence.
    always_comb begin
        if (r_func == FUNC_WRITE) begin
            n_cause = CAUSE_NONE;
        end else if (r_wall_cause != CAUSE_NONE) begin
            n_cause = r_wall_cause;
        end else if (r_hit) begin
            n_cause = CAUSE_SPHERE;
        end else begin
            n_cause = CAUSE_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_cause    <= n_cause;
            r_out_collides <= n_cause != CAUSE_NONE;
        end
    end

    assign o_cause    = r_out_cause;
    assign o_collides = r_out_collides;

`ifndef SYNTHESIS
    a_hit_only_on_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hit) |-> (r_func == FUNC_QUERY))
        else $error("sphere hit raised outside a query");
`endif

endmodule

`default_nettype wire

FILE: rtl/sphere_in_cylinder_overlap_check.sv
// Top level of the hard-sphere overlap checker inside a closed cylinder.
// Depends on sico_pkg, sico_ctrl and sico_datapath.
//
// Input channel s_axis: tuser carries func (0 write, 1 query); tdata carries index,
// skip_valid, pos_x, pos_y, pos_z. A write item stores a position at a slot; a query
// item tests a candidate against the tube wall, the end caps and every stored sphere
// in slots 0 to particle_count - 1, clamped to MAX_SPHERES, except the index slot when
// skip_valid is set. Output channel m_axis carries one item per input item, tdata =
// collides, cause. The user writes configuration through the i_cfg_ port only while
// the block is idle; the block does not enforce this. A write takes effect at the
// clock edge that samples it. One item is processed at a time. A write item passes
// through the WRITE and DONE states. A query runs the wall tests in the PREP, SQUARE
// and CHECK states, then scans the store at one entry per cycle, set by its single
// read port, through a four-stage read, difference, square and compare pipeline; a
// wall or sphere hit ends the scan early. The next item is taken the cycle after
// its result is loaded. Reset returns the controller, the scan state and the
// configuration registers to their reset values; the store is not cleared, so a slot
// must be written before a query reads it. While the receiver stalls, the next item
// is still accepted and processed; only its own result waits for the output
// register, and the input stays stalled until that register is free.
`default_nettype none

module sphere_in_cylinder_overlap_check #(
    parameter int MAX_SPHERES = sico_pkg::MAX_SPHERES_DEF,
    parameter int COORD_WIDTH = sico_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // Fields from bit 0 up: index, skip_valid, pos_x, pos_y, pos_z, zero fill.
    input  wire logic [((sico_pkg::IDX_W + 1 + 3 * COORD_WIDTH + 7) / 8) * 8 - 1:0]
                                                      s_axis_tdata,
    // Fields from bit 0 up: func.
    input  wire logic [0:0]                           s_axis_tuser,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // Fields from bit 0 up: collides, cause, zero fill.
    output logic [sico_pkg::OUT_DATA_W-1:0]           m_axis_tdata,
    input  wire logic                                 i_cfg_we,
    input  wire logic [sico_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [sico_pkg::REG_W-1:0]           i_cfg_wdata
);
    import sico_pkg::*;

    localparam int X_LO = IDX_W + 1;
    localparam int Y_LO = X_LO + COORD_WIDTH;
    localparam int Z_LO = Y_LO + COORD_WIDTH;

    t_dp_cmd            w_cmd;
    t_dp_status         w_status;
    logic               w_collides;
    logic [CAUSE_W-1:0] w_cause;

    sico_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_s_func  (s_axis_tuser[0]),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    sico_datapath #(
        .MAX_SPHERES (MAX_SPHERES),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_func       (s_axis_tuser[0]),
        .i_index      (s_axis_tdata[IDX_W-1:0]),
        .i_skip_valid (s_axis_tdata[IDX_W]),
        .i_pos_x      (s_axis_tdata[X_LO +: COORD_WIDTH]),
        .i_pos_y      (s_axis_tdata[Y_LO +: COORD_WIDTH]),
        .i_pos_z      (s_axis_tdata[Z_LO +: COORD_WIDTH]),
        .o_collides   (w_collides),
        .o_cause      (w_cause)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - CAUSE_W - 1){1'b0}}, w_cause, w_collides};

endmodule

`default_nettype wire

FILE: verif/tb_sphere_in_cylinder_overlap_check.sv
`timescale 1ns / 100ps
// Self-checking testbench for sphere_in_cylinder_overlap_check: stream items in, results
// checked against an in-bench predictor that keeps its own copy of the store and registers.
// Depends on sico_pkg and the RTL of the block only.

module tb_sphere_in_cylinder_overlap_check;
    import sico_pkg::*;

    localparam int COORD_W      = COORD_WIDTH_DEF;
    localparam int N_SLOTS      = MAX_SPHERES_DEF;
    localparam int FILL_SLOTS   = 160;
    localparam int IN_BITS      = IDX_W + 1 + 3 * COORD_W;
    localparam int IN_DATA_W    = ((IN_BITS + 7) / 8) * 8;
    localparam int CMAX         = (1 << (COORD_W - 1)) - 1;
    localparam int CMIN         = -(1 << (COORD_W - 1));
    localparam int SPAN_CAP     = 1 << 22;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 390;
    localparam int PHASE_ITEMS  = 48;
    localparam logic [REG_W-1:0] REG_MAX = '1;

    typedef logic signed [COORD_W-1:0] t_coord;

    // One input item, field by field.
    typedef struct {
        logic             func;
        logic [IDX_W-1:0] index;
        logic             skip;
        t_coord           x;
        t_coord           y;
        t_coord           z;
    } t_sphere_item;

    // One result item.
    typedef struct {
        logic               collides;
        logic [CAUSE_W-1:0] cause;
    } t_overlap_outcome;

    // A row of the directed table: either a register write or an item. Rows whose
    // result is obvious carry it typed in; the others are checked by the predictor.
    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [REG_W-1:0]     reg_val;
        t_sphere_item         item;
        logic                 typed;
        t_overlap_outcome     outcome;
    } t_stim_row;

    // Clock and block ports. Every input has a known value from time zero.
    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    // Fields from bit 0 up: index, skip_valid, pos_x, pos_y, pos_z, zero fill.
    logic [IN_DATA_W-1:0]      s_axis_tdata  = '0;
    // Fields from bit 0 up: func.
    logic [0:0]                s_axis_tuser  = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // Fields from bit 0 up: collides, cause, zero fill.
    logic [OUT_DATA_W-1:0]     m_axis_tdata;
    logic                      i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]      i_cfg_idx     = '0;
    logic [REG_W-1:0]          i_cfg_wdata   = '0;

    sphere_in_cylinder_overlap_check #(
        .MAX_SPHERES (N_SLOTS),
        .COORD_WIDTH (COORD_W)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The predictor's own copy of the block state. Slots are only read by the
    // predictor after the stimulus has written them.
    t_coord                mem_x [N_SLOTS];
    t_coord                mem_y [N_SLOTS];
    t_coord                mem_z [N_SLOTS];
    logic [REG_W-1:0]      radius_q = '0;
    logic [REG_W-1:0]      length_q = '0;
    logic [REG_W-1:0]      diam_q   = DIAMETER_RESET;
    logic [CNT_REG_W-1:0]  count_q  = '0;

    // Results still owed by the block, oldest first.
    t_overlap_outcome pending_outcomes [$];
    int               mismatch_count = 0;

    // Idling controls shared between the stimulus thread and the receiver.
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    t_stim_row directed_rows [$];

    // Works out the result of one item and applies a write to the store copy.
    // All tests are exact integer compares; nothing here exceeds 50 bits, so
    // plain 64-bit arithmetic needs no saturation.
    function automatic t_overlap_outcome predict_outcome(input t_sphere_item it);
        t_overlap_outcome res;
        longint twice_r;
        longint lim;
        longint r2x4;
        longint az;
        longint d2;
        longint dx;
        longint dy;
        longint dz;
        int     n;
        res.cause = CAUSE_NONE;
        if (it.func == FUNC_WRITE) begin
            mem_x[it.index] = it.x;
            mem_y[it.index] = it.y;
            mem_z[it.index] = it.z;
        end else begin
            twice_r = 2 * longint'(radius_q);
            r2x4 = 4 * (longint'(it.x) * longint'(it.x) + longint'(it.y) * longint'(it.y));
            // A sphere wider than the tube cannot sit anywhere in it.
            if (longint'(diam_q) > twice_r) begin
                res.cause = CAUSE_RADIAL;
            end else begin
                lim = twice_r - longint'(diam_q);
                if (r2x4 > lim * lim)
                    res.cause = CAUSE_RADIAL;
            end
            az = (it.z < 0) ? -longint'(it.z) : longint'(it.z);
            if (res.cause == CAUSE_NONE && 2 * az + longint'(diam_q) > longint'(length_q))
                res.cause = CAUSE_CAP;
            if (res.cause == CAUSE_NONE) begin
                n  = (count_q > N_SLOTS) ? N_SLOTS : int'(count_q);
                d2 = longint'(diam_q) * longint'(diam_q);
                for (int i = 0; i < n; i++) begin
                    if (it.skip && i == it.index)
                        continue;
                    dx = longint'(mem_x[i]) - longint'(it.x);
                    dy = longint'(mem_y[i]) - longint'(it.y);
                    dz = longint'(mem_z[i]) - longint'(it.z);
                    if (dx * dx + dy * dy + dz * dz < d2) begin
                        res.cause = CAUSE_SPHERE;
                        break;
                    end
                end
            end
        end
        res.collides = (res.cause != CAUSE_NONE);
        return res;
    endfunction

    // Uniform signed value in [-half, half], wrapped to the coordinate width.
    function automatic t_coord rand_span(input int half);
        return t_coord'(int'($urandom_range(0, 2 * half)) - half);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [REG_W-1:0] val);
        t_stim_row row;
        row = '{default: '0};
        row.is_cfg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic void add_item(input logic func, input int index, input logic skip,
                                     input int x, input int y, input int z,
                                     input logic typed, input logic [CAUSE_W-1:0] cause);
        t_stim_row row;
        row = '{default: '0};
        row.item.func        = func;
        row.item.index       = IDX_W'(index);
        row.item.skip        = skip;
        row.item.x           = t_coord'(x);
        row.item.y           = t_coord'(y);
        row.item.z           = t_coord'(z);
        row.typed            = typed;
        row.outcome.cause    = cause;
        row.outcome.collides = (cause != CAUSE_NONE);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Offers one item from the falling edge on and holds it until the block
    // takes it. The expectation is queued at the accepting edge, so that the
    // store copy sees items in exactly the order the block does.
    task automatic send_item(input t_sphere_item it, input logic typed,
                             input t_overlap_outcome fixed, output t_overlap_outcome predicted);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= it.func;
        s_axis_tdata  <= IN_DATA_W'({it.z, it.y, it.x, it.skip, it.index});
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        predicted = predict_outcome(it);
        pending_outcomes.insert(pending_outcomes.size(), typed ? fixed : predicted);
    endtask

    // Sometimes leaves the input channel empty for a burst of cycles.
    task automatic sender_gap();
        int n;
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 13);
            repeat (n) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
    endtask

    // Stops offering items and waits until every owed result has come out,
    // then lets the block settle so that it is surely back at rest.
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register write, only ever called while the block is idle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_TUBE_RADIUS:    radius_q = val;
            CFG_TUBE_LENGTH:    length_q = val;
            CFG_DIAMETER:       diam_q   = val;
            CFG_PARTICLE_COUNT: count_q  = val[CNT_REG_W-1:0];
            default: ;
        endcase
    endtask

    // Receiver: ready changes only at falling edges. It idles in random bursts,
    // and once on request it holds off for a long stretch so that the output
    // register fills and the block has to stall its input.
    initial begin : rx_driver
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 13);
                m_axis_tready <= 1'b0;
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Every accepted result is compared with the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_overlap_outcome got;
        t_overlap_outcome want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.collides = m_axis_tdata[0];
            got.cause    = m_axis_tdata[2:1];
            if (pending_outcomes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: result with nothing expected: collides %0b cause %0d",
                             $realtime, got.collides, got.cause);
            end else begin
                want = pending_outcomes.pop_front();
                if (got.collides !== want.collides || got.cause !== want.cause) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: mismatch: expected collides %0b cause %0d, got %0b %0d",
                                 $realtime, want.collides, want.cause, got.collides, got.cause);
                end
            end
        end
    end

    // Hard limit on the run; a correct run ends far sooner.
    initial begin : watchdog
        #(64'd100_000_000);
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        t_overlap_outcome got;
        t_overlap_outcome no_fixed;
        t_sphere_item     it;
        logic [REG_W-1:0] r;
        logic [REG_W-1:0] l;
        logic [REG_W-1:0] d;
        int               cnt;
        int               phase;
        int               random_sent;
        int               in_phase;
        int               pick;
        int               slot;
        int               limit;
        int               near;
        int               rad_span;
        int               len_span;
        bit               last;

        no_fixed = '{collides: 1'b0, cause: CAUSE_NONE};

        // Directed table. Registers start at radius 0, length 0, diameter 1.0,
        // so the very first query finds the tube too thin for any sphere.
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, 0, 1'b1, CAUSE_RADIAL);
        add_item(FUNC_WRITE, 1023, 1'b1, CMAX, CMIN, CMAX, 1'b1, CAUSE_NONE);
        // Widest tube, no spheres in use: only the walls can be hit.
        add_cfg(CFG_TUBE_RADIUS, REG_MAX);
        add_cfg(CFG_TUBE_LENGTH, REG_MAX);
        add_cfg(CFG_DIAMETER, DIAMETER_RESET);
        add_cfg(CFG_PARTICLE_COUNT, '0);
        add_item(FUNC_QUERY, 0, 1'b0, CMIN, CMIN, 0, 1'b1, CAUSE_RADIAL);
        add_item(FUNC_QUERY, 1023, 1'b1, CMAX, 0, 0, 1'b1, CAUSE_RADIAL);
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, CMAX, 1'b1, CAUSE_CAP);
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, CMIN, 1'b1, CAUSE_CAP);
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, 0, 1'b1, CAUSE_NONE);
        // Four spheres for the pairwise tests; each write is acknowledged.
        add_item(FUNC_WRITE, 0, 1'b0, 0, 0, 0, 1'b1, CAUSE_NONE);
        add_item(FUNC_WRITE, 1, 1'b0, 2560, 0, 0, 1'b1, CAUSE_NONE);
        add_item(FUNC_WRITE, 2, 1'b1, 0, -2560, 1024, 1'b1, CAUSE_NONE);
        add_item(FUNC_WRITE, 3, 1'b0, -3000, 3000, -3000, 1'b1, CAUSE_NONE);
        // Radius 5.0 with diameter 1.0 puts the radial limit exactly at x = 4.5,
        // and length 256.0 puts the end cap limit at z = 127.5.
        add_cfg(CFG_TUBE_RADIUS, 23'd1280);
        add_cfg(CFG_TUBE_LENGTH, 23'd65536);
        add_cfg(CFG_PARTICLE_COUNT, 23'd4);
        add_item(FUNC_QUERY, 0, 1'b0, 1152, 0, 0, 1'b0, CAUSE_NONE);
        add_item(FUNC_QUERY, 0, 1'b0, 1153, 0, 0, 1'b1, CAUSE_RADIAL);
        add_item(FUNC_QUERY, 0, 1'b0, 256, 0, 0, 1'b0, CAUSE_NONE);
        add_item(FUNC_QUERY, 0, 1'b0, 255, 0, 0, 1'b0, CAUSE_NONE);
        add_item(FUNC_QUERY, 0, 1'b1, 255, 0, 0, 1'b0, CAUSE_NONE);
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, 32640, 1'b0, CAUSE_NONE);
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, -32641, 1'b1, CAUSE_CAP);
        // A zero diameter never reports a sphere, even at a stored centre.
        add_cfg(CFG_DIAMETER, '0);
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, 0, 1'b0, CAUSE_NONE);
        // Largest diameter in the largest tube: the cap sits exactly at z = 0.
        add_cfg(CFG_TUBE_RADIUS, REG_MAX);
        add_cfg(CFG_TUBE_LENGTH, REG_MAX);
        add_cfg(CFG_DIAMETER, REG_MAX);
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, 0, 1'b0, CAUSE_NONE);
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, 1, 1'b1, CAUSE_CAP);
        // Everything zero: the origin just fits, one step off it does not.
        add_cfg(CFG_TUBE_RADIUS, '0);
        add_cfg(CFG_TUBE_LENGTH, '0);
        add_cfg(CFG_DIAMETER, '0);
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, 0, 1'b0, CAUSE_NONE);
        add_item(FUNC_QUERY, 0, 1'b0, 1, 0, 0, 1'b1, CAUSE_RADIAL);
        // Diameter 1.0 against a tube of diameter 0.99: too thin everywhere.
        add_cfg(CFG_TUBE_RADIUS, 23'd127);
        add_cfg(CFG_TUBE_LENGTH, 23'd65536);
        add_cfg(CFG_DIAMETER, DIAMETER_RESET);
        add_item(FUNC_QUERY, 0, 1'b0, 0, 0, 0, 1'b1, CAUSE_RADIAL);

        // Reset is held from time zero and released at a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].is_cfg) begin
                wait_idle();
                write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
            end else begin
                send_item(directed_rows[k].item, directed_rows[k].typed,
                          directed_rows[k].outcome, got);
                sender_gap();
            end
        end

        // Fill the low slots once; particle counts stay within them from here
        // on. Centres cluster near the axis so that queries meet them.
        for (int i = 0; i < FILL_SLOTS; i++) begin
            it.func  = FUNC_WRITE;
            it.index = IDX_W'(i);
            it.skip  = 1'($urandom_range(0, 1));
            it.x     = rand_span(6000);
            it.y     = rand_span(6000);
            it.z     = rand_span(20000);
            send_item(it, 1'b0, no_fixed, got);
            sender_gap();
        end

        // Random phases, each under its own register setting. Most steps are
        // Monte Carlo style moves: a query near a sphere that skips that sphere,
        // followed by the write of the new centre when the move is free.
        phase       = 0;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            wait_idle();
            last       = (random_sent + PHASE_ITEMS >= RANDOM_ITEMS);
            tx_idle_on = !last && ($urandom_range(0, 4) != 0);
            rx_idle_on = !last && ($urandom_range(0, 4) != 0);

            if ($urandom_range(0, 5) == 0) begin
                r = REG_W'($urandom_range(0, REG_MAX));
                l = REG_W'($urandom_range(0, REG_MAX));
                d = REG_W'($urandom_range(0, REG_MAX));
            end else begin
                r = REG_W'($urandom_range(4096, 65535));
                l = REG_W'($urandom_range(16384, 262143));
                d = REG_W'($urandom_range(64, 1024));
            end
            if (phase == 1)
                d = '0;
            if (phase == 2) begin
                r = REG_MAX;
                l = REG_MAX;
                d = REG_MAX;
            end
            cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(0, FILL_SLOTS)
                                              : $urandom_range(1, 24);
            if (phase == 3)
                cnt = FILL_SLOTS;
            write_reg(CFG_TUBE_RADIUS, r);
            write_reg(CFG_TUBE_LENGTH, l);
            write_reg(CFG_DIAMETER, d);
            write_reg(CFG_PARTICLE_COUNT, REG_W'(cnt));

            // One phase starts with a long receiver hold while items keep coming.
            if (phase == 4)
                hold_req = 1'b1;

            limit    = (count_q > N_SLOTS) ? N_SLOTS : int'(count_q);
            near     = ((diam_q > 2048) ? 2048 : int'(diam_q)) + 16;
            rad_span = (radius_q > SPAN_CAP) ? SPAN_CAP : int'(radius_q);
            len_span = (length_q / 2 > SPAN_CAP) ? SPAN_CAP : int'(length_q / 2);

            in_phase = 0;
            while (in_phase < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                slot = (limit == 0) ? 0 : $urandom_range(0, limit - 1);
                it.func  = FUNC_QUERY;
                it.index = IDX_W'(slot);
                it.skip  = 1'b0;
                if (pick < 55 && limit != 0) begin
                    it.skip = 1'b1;
                    it.x    = mem_x[slot] + rand_span(near);
                    it.y    = mem_y[slot] + rand_span(near);
                    it.z    = mem_z[slot] + rand_span(near);
                    send_item(it, 1'b0, no_fixed, got);
                    in_phase++;
                    sender_gap();
                    if (!got.collides) begin
                        it.func = FUNC_WRITE;
                        it.skip = 1'($urandom_range(0, 1));
                        send_item(it, 1'b0, no_fixed, got);
                        in_phase++;
                        sender_gap();
                    end
                end else begin
                    if (pick < 75 && limit != 0) begin
                        // Query near a sphere; the skip slot is random or absent.
                        it.index = IDX_W'($urandom_range(0, N_SLOTS - 1));
                        it.skip  = 1'($urandom_range(0, 1));
                        it.x     = mem_x[slot] + rand_span(near);
                        it.y     = mem_y[slot] + rand_span(near);
                        it.z     = mem_z[slot] + rand_span(near);
                    end else if (pick < 85) begin
                        // Plain write to any slot, near another centre.
                        it.func  = FUNC_WRITE;
                        it.index = IDX_W'($urandom_range(0, N_SLOTS - 1));
                        it.skip  = 1'($urandom_range(0, 1));
                        it.x     = mem_x[slot] + rand_span(4 * near);
                        it.y     = mem_y[slot] + rand_span(4 * near);
                        it.z     = mem_z[slot] + rand_span(4 * near);
                    end else if (pick < 97) begin
                        // Noise over the full width of every field.
                        it.func  = 1'($urandom_range(0, 1));
                        it.index = IDX_W'($urandom_range(0, N_SLOTS - 1));
                        it.skip  = 1'($urandom_range(0, 1));
                        it.x     = t_coord'($urandom);
                        it.y     = t_coord'($urandom);
                        it.z     = t_coord'($urandom);
                    end else begin
                        // Anywhere in a box around the tube (spans capped at SPAN_CAP), sphere or not.
                        it.x = rand_span(rad_span);
                        it.y = rand_span(rad_span);
                        it.z = rand_span(len_span);
                    end
                    send_item(it, 1'b0, no_fixed, got);
                    in_phase++;
                    sender_gap();
                end
                // Now and then the sender waits for the block to drain completely.
                if ($urandom_range(0, 63) == 0)
                    wait_idle();
            end
            random_sent += in_phase;
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/sico_pkg.sv
rtl/sico_ctrl.sv
rtl/sico_datapath.sv
rtl/sphere_in_cylinder_overlap_check.sv
verif/tb_sphere_in_cylinder_overlap_check.sv
